### rtl/lutq_pkg.sv
// Shared types and constants for the cube LUT entry quantizer.
// Holds field widths, configuration register indexes and reset values.
// No dependencies.
package lutq_pkg;

    localparam int VALUE_W   = 32;   // signed Q15.16 input and domain bound
    localparam int OUT_W     = 16;   // quantized channel
    localparam int ENTRY_W   = 21;   // entry_index field
    localparam int CFG_W     = 32;   // widest configuration register
    localparam int SIDE_REG_W = 8;   // lut_side register
    localparam int NUM_CH    = 3;

    // Division datapath: numerator 2*d*65535 + span, divisor 2*span.
    localparam int DIFF_W    = VALUE_W + 1;
    localparam int NUM_W     = DIFF_W + 18;
    localparam int DSH_W     = DIFF_W + 17;
    localparam int QBIT_W    = 4;

    localparam logic [SIDE_REG_W-1:0] LUT_MIN_SIDE   = 8'd2;
    localparam logic [SIDE_REG_W-1:0] LUT_SIDE_RESET = 8'd2;
    localparam logic [VALUE_W-1:0]    DOM_LOW_RESET  = 32'h0000_0000;
    localparam logic [VALUE_W-1:0]    DOM_HIGH_RESET = 32'h0001_0000;

    typedef logic [2:0] cfg_addr_t;

    localparam cfg_addr_t CFG_LUT_SIDE   = 3'd0;
    localparam cfg_addr_t CFG_RED_LOW    = 3'd1;
    localparam cfg_addr_t CFG_RED_HIGH   = 3'd2;
    localparam cfg_addr_t CFG_GREEN_LOW  = 3'd3;
    localparam cfg_addr_t CFG_GREEN_HIGH = 3'd4;
    localparam cfg_addr_t CFG_BLUE_LOW   = 3'd5;
    localparam cfg_addr_t CFG_BLUE_HIGH  = 3'd6;

    localparam int S_TDATA_W = NUM_CH * VALUE_W;                       // 96
    localparam int M_TDATA_W = ((ENTRY_W + NUM_CH * OUT_W + 7) / 8) * 8; // 72

endpackage

### rtl/lut_entry_quantize_and_place_top.sv
// Cube LUT entry quantizer: maps each color triple onto 16-bit channels
// and places it in the cube raster. Depends on lutq_pkg.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, one color triple each.
//   Each word yields one result word on m_tvalid/m_tready/m_tdata with the
//   cube entry index and the three quantized channels; m_tlast marks the
//   entry that completes the cube and m_tuser flags entries beyond it.
//   Configuration (cube side, per-channel domain) is written through
//   cfg_wr_en/cfg_addr/cfg_wr_data while the block is idle.
// Timing:
//   An item passes through accept (idle), differences and the row term of
//   the index, numerator and divisor setup, the restoring division (one
//   quotient bit per cycle, three channels side by side), and the load of
//   the output register. s_tready is high only in the idle state.
// Reset and stall:
//   aresetn (synchronous, active low) restores side 2 and domain 0..1 and
//   clears the raster counters and entry count. A stalled receiver holds
//   the result in the output register; the next input word is still taken
//   and processed, and waits for the register before it is loaded.
module lut_entry_quantize_and_place_top #(
    parameter int MAX_SIDE = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: red_value[31:0], green_value[63:32], blue_value[95:64]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lutq_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: entry_index[20:0], red_out[36:21], green_out[52:37],
    //          blue_out[68:53], zero fill above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lutq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,   // cube_complete
    output logic                          m_tuser,   // overflow
    input  logic                          cfg_wr_en,
    input  lutq_pkg::cfg_addr_t           cfg_addr,
    input  logic [lutq_pkg::CFG_W-1:0]    cfg_wr_data
);
    import lutq_pkg::*;

    localparam int POS_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int SQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int T1_W   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int IDX_W  = $clog2(MAX_SIDE * MAX_SIDE * MAX_SIDE);
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE * MAX_SIDE + 2);
    localparam logic [SIDE_REG_W-1:0] MAX_SIDE_B = SIDE_REG_W'(MAX_SIDE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [SIDE_REG_W-1:0] lut_side_reg;
    logic [VALUE_W-1:0]    dom_low_reg  [NUM_CH];
    logic [VALUE_W-1:0]    dom_high_reg [NUM_CH];

    // raster position and entry count
    logic [POS_W-1:0] column_pos_reg;
    logic [POS_W-1:0] row_pos_reg;
    logic [POS_W-1:0] slice_pos_reg;
    logic [CNT_W-1:0] entries_seen_reg;

    // per-item datapath
    logic [VALUE_W-1:0]       val_reg  [NUM_CH];
    logic signed [DIFF_W-1:0] diff_reg [NUM_CH];
    logic signed [DIFF_W-1:0] span_reg [NUM_CH];
    logic                     zero_reg [NUM_CH];
    logic                     full_reg [NUM_CH];
    logic [NUM_W-1:0]         rem_reg  [NUM_CH];
    logic [DSH_W-1:0]         dsh_reg  [NUM_CH];
    logic [OUT_W-1:0]         quo_reg  [NUM_CH];
    logic [QBIT_W-1:0]        bit_cnt_reg;
    logic [T1_W-1:0]          t1_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         cube_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    logic [SIDE_W-1:0] side_eff;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  col_clamp;
    logic [POS_W-1:0]  row_clamp;
    logic [POS_W-1:0]  slice_clamp;
    logic [NUM_W-1:0]  rem_next [NUM_CH];
    logic              qbit     [NUM_CH];
    logic [OUT_W-1:0]  chan_out [NUM_CH];
    logic [CNT_W-1:0]  seen_inc;
    logic [CNT_W-1:0]  seen_next;
    logic              out_free;

    always_comb begin
        if (lut_side_reg < LUT_MIN_SIDE) begin
            side_eff = SIDE_W'(LUT_MIN_SIDE);
        end else if (lut_side_reg > MAX_SIDE_B) begin
            side_eff = SIDE_W'(MAX_SIDE_B);
        end else begin
            side_eff = SIDE_W'(lut_side_reg);
        end
        last_pos    = POS_W'(side_eff - SIDE_W'(1));
        col_clamp   = (column_pos_reg > last_pos) ? last_pos : column_pos_reg;
        row_clamp   = (row_pos_reg > last_pos) ? last_pos : row_pos_reg;
        slice_clamp = (slice_pos_reg > last_pos) ? last_pos : slice_pos_reg;

        for (int c = 0; c < NUM_CH; c++) begin
            qbit[c]     = (rem_reg[c] >= NUM_W'(dsh_reg[c]));
            rem_next[c] = qbit[c] ? (rem_reg[c] - NUM_W'(dsh_reg[c])) : rem_reg[c];
            if (zero_reg[c]) begin
                chan_out[c] = '0;
            end else if (full_reg[c]) begin
                chan_out[c] = '1;
            end else begin
                chan_out[c] = quo_reg[c];
            end
        end

        // saturate the count at side cubed plus one
        seen_inc  = entries_seen_reg + CNT_W'(1);
        seen_next = (seen_inc > cube_reg + CNT_W'(1)) ? cube_reg + CNT_W'(1) : seen_inc;
        out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            lut_side_reg     <= LUT_SIDE_RESET;
            for (int c = 0; c < NUM_CH; c++) begin
                dom_low_reg[c]  <= DOM_LOW_RESET;
                dom_high_reg[c] <= DOM_HIGH_RESET;
            end
            column_pos_reg   <= '0;
            row_pos_reg      <= '0;
            slice_pos_reg    <= '0;
            entries_seen_reg <= '0;
            bit_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_LUT_SIDE:   lut_side_reg    <= cfg_wr_data[SIDE_REG_W-1:0];
                    CFG_RED_LOW:    dom_low_reg[0]  <= cfg_wr_data;
                    CFG_RED_HIGH:   dom_high_reg[0] <= cfg_wr_data;
                    CFG_GREEN_LOW:  dom_low_reg[1]  <= cfg_wr_data;
                    CFG_GREEN_HIGH: dom_high_reg[1] <= cfg_wr_data;
                    CFG_BLUE_LOW:   dom_low_reg[2]  <= cfg_wr_data;
                    CFG_BLUE_HIGH:  dom_high_reg[2] <= cfg_wr_data;
                    default: ;
                endcase
            end

            // drop a taken word; a load in ST_DONE sets valid instead
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int c = 0; c < NUM_CH; c++) begin
                            val_reg[c] <= s_tdata[c*VALUE_W +: VALUE_W];
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        diff_reg[c] <= $signed({val_reg[c][VALUE_W-1], val_reg[c]})
                                     - $signed({dom_low_reg[c][VALUE_W-1], dom_low_reg[c]});
                        span_reg[c] <= $signed({dom_high_reg[c][VALUE_W-1], dom_high_reg[c]})
                                     - $signed({dom_low_reg[c][VALUE_W-1], dom_low_reg[c]});
                    end
                    // pull counters back inside a cube that shrank
                    column_pos_reg <= col_clamp;
                    row_pos_reg    <= row_clamp;
                    slice_pos_reg  <= slice_clamp;
                    t1_reg <= T1_W'(T1_W'(slice_clamp) * T1_W'(side_eff)) + T1_W'(row_clamp);
                    sq_reg <= SQ_W'(SQ_W'(side_eff) * SQ_W'(side_eff));
                    state_reg <= ST_SETUP;
                end
                ST_SETUP: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        zero_reg[c] <= (span_reg[c] <= 33'sd0) || (diff_reg[c] <= 33'sd0);
                        full_reg[c] <= (diff_reg[c] >= span_reg[c]);
                        // 2*d*65535 + span, d*65535 as (d << 16) - d
                        rem_reg[c]  <= (NUM_W'($unsigned(diff_reg[c])) << 17)
                                     - (NUM_W'($unsigned(diff_reg[c])) << 1)
                                     + NUM_W'($unsigned(span_reg[c]));
                        // divisor 2*span aligned to the top quotient bit
                        dsh_reg[c]  <= DSH_W'($unsigned(span_reg[c])) << 16;
                        quo_reg[c]  <= '0;
                    end
                    idx_reg  <= IDX_W'(IDX_W'(t1_reg) * IDX_W'(side_eff))
                              + IDX_W'(column_pos_reg);
                    cube_reg <= CNT_W'(CNT_W'(sq_reg) * CNT_W'(side_eff));
                    bit_cnt_reg <= QBIT_W'(OUT_W - 1);
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        rem_reg[c] <= rem_next[c];
                        quo_reg[c] <= {quo_reg[c][OUT_W-2:0], qbit[c]};
                        dsh_reg[c] <= dsh_reg[c] >> 1;
                    end
                    if (bit_cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        bit_cnt_reg <= bit_cnt_reg - QBIT_W'(1);
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({chan_out[2], chan_out[1], chan_out[0],
                                                    ENTRY_W'(idx_reg)});
                        m_tlast_reg  <= (seen_next == cube_reg);
                        m_tuser_reg  <= (seen_next > cube_reg);
                        entries_seen_reg <= seen_next;
                        if (column_pos_reg != last_pos) begin
                            column_pos_reg <= column_pos_reg + POS_W'(1);
                        end else if (row_pos_reg != last_pos) begin
                            row_pos_reg    <= row_pos_reg + POS_W'(1);
                            column_pos_reg <= '0;
                        end else if (slice_pos_reg != last_pos) begin
                            slice_pos_reg  <= slice_pos_reg + POS_W'(1);
                            column_pos_reg <= '0;
                            row_pos_reg    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the cube LUT entry quantizer and placer.
// Drives color triples and register writes, predicts each result word and checks it.
// Depends on rtl/lutq_pkg.sv and rtl/lut_entry_quantize_and_place_top.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lutq_pkg::*;

    localparam int        LUT_MAX_SIDE = 128;
    localparam int        QUIET_LIMIT  = 1000;
    localparam int        DRAIN_CYCLES = 25;
    localparam cfg_addr_t CFG_SPARE    = 3'd7;   // no register behind this index

    typedef struct {
        logic [ENTRY_W-1:0] index;
        logic [OUT_W-1:0]   chan [NUM_CH];
        logic               complete;
        logic               over;
    } lut_entry_t;

    class lut_entry_scoreboard;
        logic [SIDE_REG_W-1:0]   side_reg;
        logic signed [VALUE_W-1:0] dom_low  [NUM_CH];
        logic signed [VALUE_W-1:0] dom_high [NUM_CH];
        logic [6:0]              col_pos, row_pos, slice_pos;
        int unsigned             entries_seen;
        lut_entry_t              expected_entries [$];
        int                      mismatches, results_checked, completions, overflows;

        function new();
            side_reg = LUT_SIDE_RESET;
            for (int c = 0; c < NUM_CH; c++) begin
                dom_low[c]  = DOM_LOW_RESET;
                dom_high[c] = DOM_HIGH_RESET;
            end
            col_pos = 0;
            row_pos = 0;
            slice_pos = 0;
            entries_seen = 0;
            mismatches = 0;
            results_checked = 0;
            completions = 0;
            overflows = 0;
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        function void write_reg(cfg_addr_t addr, logic [CFG_W-1:0] data);
            case (addr)
                CFG_LUT_SIDE:   side_reg    = data[SIDE_REG_W-1:0];
                CFG_RED_LOW:    dom_low[0]  = data;
                CFG_RED_HIGH:   dom_high[0] = data;
                CFG_GREEN_LOW:  dom_low[1]  = data;
                CFG_GREEN_HIGH: dom_high[1] = data;
                CFG_BLUE_LOW:   dom_low[2]  = data;
                CFG_BLUE_HIGH:  dom_high[2] = data;
                default: ;
            endcase
        endfunction

        // Map value from [lo, hi] onto 0..65535, rounding half up.
        function logic [OUT_W-1:0] scaled_channel(logic [VALUE_W-1:0] raw,
                                                   logic signed [VALUE_W-1:0] lo,
                                                   logic signed [VALUE_W-1:0] hi);
            longint span, diff, num;
            span = longint'(hi) - longint'(lo);
            diff = longint'($signed(raw)) - longint'(lo);
            if (span <= 0 || diff <= 0)
                return '0;
            if (diff >= span)
                return '1;
            num = diff * 2 * 65535 + span;
            return OUT_W'(num / (2 * span));
        endfunction

        function void note_triple(logic [S_TDATA_W-1:0] word);
            lut_entry_t  e;
            int unsigned side, last_pos, cube, n, idx;
            side = side_reg;
            if (side < LUT_MIN_SIDE)
                side = LUT_MIN_SIDE;
            if (side > LUT_MAX_SIDE)
                side = LUT_MAX_SIDE;
            last_pos = side - 1;
            cube = side * side * side;
            // a smaller side pulls stale counters back to the last cell
            if (col_pos > last_pos)
                col_pos = last_pos[6:0];
            if (row_pos > last_pos)
                row_pos = last_pos[6:0];
            if (slice_pos > last_pos)
                slice_pos = last_pos[6:0];
            idx = (slice_pos * side + row_pos) * side + col_pos;
            e.index = idx[ENTRY_W-1:0];
            for (int c = 0; c < NUM_CH; c++)
                e.chan[c] = scaled_channel(word[c*VALUE_W +: VALUE_W], dom_low[c], dom_high[c]);
            n = entries_seen + 1;
            if (n > cube + 1)
                n = cube + 1;
            entries_seen = n;
            e.complete = (n == cube);
            e.over = (n > cube);
            if (col_pos != last_pos) begin
                col_pos++;
            end else if (row_pos != last_pos) begin
                row_pos++;
                col_pos = 0;
            end else if (slice_pos != last_pos) begin
                slice_pos++;
                col_pos = 0;
                row_pos = 0;
            end
            expected_entries.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic last_flag, logic over_flag);
            lut_entry_t want;
            string      names [NUM_CH];
            logic [OUT_W-1:0] got;
            names = '{"red_out", "green_out", "blue_out"};
            if (expected_entries.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", data));
                return;
            end
            want = expected_entries.pop_front();
            results_checked++;
            if (want.complete)
                completions++;
            if (want.over)
                overflows++;
            if (data[ENTRY_W-1:0] != want.index)
                report_mismatch($sformatf("entry_index got %0d want %0d",
                                          data[ENTRY_W-1:0], want.index));
            for (int c = 0; c < NUM_CH; c++) begin
                got = data[ENTRY_W + c*OUT_W +: OUT_W];
                if (got != want.chan[c])
                    report_mismatch($sformatf("%s got %h want %h (entry %0d)",
                                              names[c], got, want.chan[c], want.index));
            end
            if (last_flag != want.complete)
                report_mismatch($sformatf("cube_complete got %b want %b (entry %0d)",
                                          last_flag, want.complete, want.index));
            if (over_flag != want.over)
                report_mismatch($sformatf("overflow got %b want %b (entry %0d)",
                                          over_flag, want.over, want.index));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    cfg_addr_t              cfg_addr = CFG_LUT_SIDE;
    logic [CFG_W-1:0]       cfg_wr_data = '0;

    lut_entry_scoreboard sb = new();

    bit idle_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int triples_sent = 0;
    int writes_done = 0;

    cfg_addr_t low_addr  [NUM_CH] = '{CFG_RED_LOW, CFG_GREEN_LOW, CFG_BLUE_LOW};
    cfg_addr_t high_addr [NUM_CH] = '{CFG_RED_HIGH, CFG_GREEN_HIGH, CFG_BLUE_HIGH};

    // red, green, blue of the directed triples
    logic [VALUE_W-1:0] dir_triples [20][NUM_CH] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
        '{32'h0000_8000, 32'h0000_0001, 32'h0000_FFFF},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h0001_0001, 32'h0000_7FFF, 32'h0000_C000},
        '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003},
        '{32'h0000_4000, 32'hFFFF_0000, 32'h0001_0001},
        '{32'h0000_8001, 32'h5555_5555, 32'hAAAA_AAAA},
        '{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h1234_5678},
        '{32'h4000_0000, 32'h3FFF_FFFF, 32'h0000_0000},
        '{32'h8000_0000, 32'h0001_0000, 32'h0001_0000},
        '{32'h7FFF_FFFF, 32'h0001_0001, 32'h0000_8000},
        '{32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0000},
        '{32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_0000},
        '{32'h0000_0000, 32'h8000_0002, 32'h0001_0000},
        '{32'h0000_8000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_FFFF}
    };

    lut_entry_quantize_and_place_top #(
        .MAX_SIDE(LUT_MAX_SIDE)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: check accepted words, then pick the next ready level.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser);
        if (stall_left != 0) begin
            stall_left--;
        end else if (idle_on) begin
            if ($urandom_range(0, 999) < 4)
                stall_left = $urandom_range(20, 45);
            else if ($urandom_range(0, 99) < 3)
                stall_left = $urandom_range(1, 6);
        end
        m_tready <= (stall_left == 0);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_triple(logic [VALUE_W-1:0] red, logic [VALUE_W-1:0] green,
                               logic [VALUE_W-1:0] blue);
        if (idle_on && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_triple({blue, green, red});
        triples_sent++;
    endtask

    // Drop valid and let every outstanding result come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_addr_t addr, logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.write_reg(addr, data);
        writes_done++;
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int     phase;
        int     count;
        int     pick;
        longint lo, hi, span, v;
        logic [VALUE_W-1:0] vals [NUM_CH];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: side 2, unit domain; the eighth entry completes the cube.
        for (int i = 0; i < 10; i++)
            send_triple(dir_triples[i][0], dir_triples[i][1], dir_triples[i][2]);
        drain_results();

        // Side below minimum with junk in the upper bits, full-range red,
        // zero-span green, inverted blue, and a write to the spare index.
        write_reg(CFG_LUT_SIDE, 32'h5A5A_5A00);
        write_reg(CFG_RED_LOW, 32'h8000_0000);
        write_reg(CFG_RED_HIGH, 32'h7FFF_FFFF);
        write_reg(CFG_GREEN_LOW, 32'h0001_0000);
        write_reg(CFG_GREEN_HIGH, 32'h0001_0000);
        write_reg(CFG_BLUE_LOW, 32'h0001_0000);
        write_reg(CFG_BLUE_HIGH, 32'h0000_0000);
        write_reg(CFG_SPARE, $urandom);
        end_writes();
        for (int i = 10; i < 15; i++)
            send_triple(dir_triples[i][0], dir_triples[i][1], dir_triples[i][2]);
        drain_results();

        // Side above maximum, extreme inverted red, one-LSB green span, symmetric blue.
        write_reg(CFG_LUT_SIDE, 32'h0000_00FF);
        write_reg(CFG_RED_LOW, 32'h7FFF_FFFF);
        write_reg(CFG_RED_HIGH, 32'h8000_0000);
        write_reg(CFG_GREEN_LOW, 32'h8000_0000);
        write_reg(CFG_GREEN_HIGH, 32'h8000_0001);
        write_reg(CFG_BLUE_LOW, 32'hFFFF_0000);
        write_reg(CFG_BLUE_HIGH, 32'h0001_0000);
        end_writes();
        for (int i = 15; i < 20; i++)
            send_triple(dir_triples[i][0], dir_triples[i][1], dir_triples[i][2]);
        drain_results();

        phase = 0;
        while (triples_sent < 400) begin
            // two back-to-back phases run with both sides at full rate
            idle_on = !(phase == 2 || phase == 3);

            if ($urandom_range(0, 9) < 8) begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    v = $urandom_range(2, 5);
                else if (pick == 6)
                    v = $urandom_range(0, 1);
                else if (pick == 7)
                    v = LUT_MAX_SIDE;
                else if (pick == 8)
                    v = $urandom_range(LUT_MAX_SIDE + 1, 255);
                else
                    v = $urandom_range(6, LUT_MAX_SIDE - 1);
                write_reg(CFG_LUT_SIDE, {24'($urandom_range(0, 32'h00FF_FFFF)), v[7:0]});
            end
            for (int c = 0; c < NUM_CH; c++) begin
                if ($urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, 9);
                    lo = longint'($urandom_range(0, 2097152)) - 1048576;
                    if (pick <= 5) begin
                        hi = lo + $urandom_range(1, 1048576);
                    end else if (pick == 6) begin
                        lo = -2147483648;
                        hi = 2147483647;
                    end else if (pick == 7) begin
                        hi = lo;
                    end else if (pick == 8) begin
                        hi = lo - $urandom_range(1, 1048576);
                    end else begin
                        lo = longint'($signed($urandom));
                        hi = longint'($signed($urandom));
                    end
                    write_reg(low_addr[c], lo[31:0]);
                    write_reg(high_addr[c], hi[31:0]);
                end
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_SPARE, $urandom);
            end_writes();

            count = $urandom_range(20, 40);
            for (int k = 0; k < count; k++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    lo = longint'(sb.dom_low[c]);
                    hi = longint'(sb.dom_high[c]);
                    span = hi - lo;
                    pick = $urandom_range(0, 9);
                    if (pick <= 5 && span > 0)
                        v = lo + $urandom_range(0, span[31:0]);
                    else if (pick == 6)
                        v = ($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 2) - 1;
                    else if (pick == 8)
                        v = $urandom_range(0, 1) ? 2147483647 : -2147483648;
                    else if (pick == 9)
                        v = $urandom_range(0, 1) ? lo - $urandom_range(1, 65536)
                                                 : hi + $urandom_range(1, 65536);
                    else
                        v = longint'($signed($urandom));
                    vals[c] = v[31:0];
                end
                send_triple(vals[0], vals[1], vals[2]);
            end
            drain_results();
            phase++;
        end

        idle_on = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("run covered %0d triples in %0d phases with %0d register writes",
                 triples_sent, phase + 3, writes_done);
        $display("checked %0d results: %0d cube completions, %0d entries past the cube",
                 sb.results_checked, sb.completions, sb.overflows);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
